>>> sv/fit_policy_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fit policy block allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FPBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FPBA_ASSERT(lbl, prop, msg)
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Codes and the command and status bundles shared by controller and datapath.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;
	localparam logic [1:0] FIT_WORST = 2'd3;

	localparam logic [1:0] STS_DONE    = 2'd0;
	localparam logic [1:0] STS_NOFIT   = 2'd1;
	localparam logic [1:0] STS_IGNORED = 2'd2;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_HEAP   = 2'd1;

	typedef struct packed {
		logic       init;
		logic       load;
		logic       scan;
		logic       latch;
		logic       sw_up;
		logic       alloc_split;
		logic       alloc_write;
		logic       rd_next;
		logic       rd_prev;
		logic       cap_next;
		logic       cap_prev;
		logic       merge;
		logic       sweep;
		logic       respond;
		logic [1:0] resp_status;
	} cmd_t;

	typedef struct packed {
		logic cfg_hit;
		logic scan_done;
		logic found;
		logic is_release;
		logic split;
		logic sw_busy;
		logic out_free;
	} sts_t;

endpackage

>>> sv/fpba_dp.sv
// ----------------------------------------------------------------------------
// fpba_dp
// Block table memory, scan comparators, split and merge arithmetic, entry
// shifting, configuration and result registers.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_macros.svh"

module fpba_dp #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int HEAP_ADDR_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [16:0]   cfg_data,
	input  logic [31:0]   s_tdata,
	input  logic          s_tuser,
	input  logic          m_tready,
	output logic          m_tvalid,
	output logic [15:0]   m_tdata,
	output logic [1:0]    m_tuser,
	input  fpba_pkg::cmd_t cmd,
	output fpba_pkg::sts_t sts
);
	import fpba_pkg::*;

	localparam int AW  = HEAP_ADDR_BITS;
	localparam int EW  = 2 * AW + 1;
	localparam int CW  = ((AW > 16) ? AW : 16) + 2;
	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int CNW = $clog2(MAX_BLOCKS + 1);
	localparam int XW  = CNW + 1;
	localparam logic [CW-1:0] HB_C   = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] TOP_C  = CW'(1) << AW;
	localparam logic [XW-1:0] MAXB_C = XW'(MAX_BLOCKS);

	logic [1:0]    policy_q;
	logic [16:0]   heap_q;
	logic          func_q;
	logic [15:0]   req_q;
	logic [15:0]   off_q;
	logic [CW-1:0] aligned_q;
	logic [CNW-1:0] count_q;
	logic [IW-1:0] cursor_q;
	logic          cur_v_q;

	logic [EW-1:0] mem [MAX_BLOCKS];
	logic [EW-1:0] rd_q;

	logic [CNW-1:0] scn_j_q;
	logic          scn_v_s1;
	logic [IW-1:0] scn_idx_s1;

	logic          found_q;
	logic          exact_q;
	logic          split_q;
	logic [IW-1:0] fidx_q;
	logic [AW-1:0] fstart_q;
	logic [AW-1:0] fsize_q;

	logic          nx_used_q;
	logic [AW-1:0] nx_size_q;
	logic          pv_used_q;
	logic [AW-1:0] pv_start_q;
	logic [AW-1:0] pv_size_q;

	logic          sw_run_q;
	logic          sw_up_q;
	logic [1:0]    sw_dist_q;
	logic [IW-1:0] sw_ptr_q;
	logic [IW-1:0] sw_last_q;
	logic          sw_v_s1;
	logic [IW-1:0] sw_dst_s1;

	logic          out_v_q;
	logic [1:0]    status_q;
	logic [15:0]   pay_q;

	logic          e_used;
	logic [AW-1:0] e_start;
	logic [AW-1:0] e_size;
	logic [CW-1:0] e_size_c;
	logic [CW-1:0] req_c;
	logic [CW-1:0] fsize_c;
	logic [XW-1:0] count_x;
	logic [XW-1:0] fidx_x;
	logic [XW-1:0] s_x;
	logic [XW-1:0] sum_x;
	logic [XW-1:0] scan_addr_x;
	logic [IW-1:0] scan_addr;
	logic          take;
	logic          hit_exact;
	logic          split_c;
	logic          has_next;
	logic          has_prev;
	logic          nf;
	logic          pf;
	logic [CW-1:0] kmerged_c;
	logic [CW-1:0] pmerged_c;
	logic [1:0]    drop_n;
	logic [XW-1:0] m_src_x;
	logic          m_run;
	logic [XW-1:0] c1;
	logic [XW-1:0] c2;
	logic [CW-1:0] h1;
	logic [CW-1:0] h2;
	logic [CW-1:0] h3;
	logic [AW-1:0] size0;
	logic [CW-1:0] pay_full_c;
	logic [CW-1:0] nstart_c;
	logic [CW-1:0] nsize_c;
	logic          cfg_hit;
	logic          we;
	logic [IW-1:0] wa;
	logic [EW-1:0] wd;
	logic [IW-1:0] ra;

	assign cfg_hit = cfg_valid && (cfg_index == REG_POLICY || cfg_index == REG_HEAP);

	assign e_used   = rd_q[EW-1];
	assign e_start  = rd_q[EW-2:AW];
	assign e_size   = rd_q[AW-1:0];
	assign e_size_c = CW'(e_size);
	assign req_c    = CW'(req_q);
	assign fsize_c  = CW'(fsize_q);
	assign count_x  = XW'(count_q);
	assign fidx_x   = XW'(fidx_q);

	// Next fit walks the table starting at the cursor and wraps at the count.
	always_comb begin
		s_x = '0;
		if (policy_q == FIT_NEXT && func_q == FUNC_ALLOC && cur_v_q &&
		    XW'(cursor_q) < count_x) begin
			s_x = XW'(cursor_q);
		end
		sum_x = s_x + XW'(scn_j_q);
		scan_addr_x = (sum_x >= count_x) ? sum_x - count_x : sum_x;
	end
	assign scan_addr = scan_addr_x[IW-1:0];

	always_comb begin
		take = 1'b0;
		hit_exact = 1'b0;
		if (func_q == FUNC_RELEASE) begin
			take = !found_q && (CW'(e_start) + HB_C == CW'(off_q));
		end else if (!e_used) begin
			case (policy_q)
				FIT_FIRST: take = !found_q && e_size_c >= req_c;
				FIT_NEXT:  take = !found_q && e_size_c >= req_c;
				FIT_BEST: begin
					if (!exact_q) begin
						if (e_size_c == req_c) begin
							take = 1'b1;
							hit_exact = 1'b1;
						end else if (e_size_c > req_c && (!found_q || e_size_c < fsize_c)) begin
							take = 1'b1;
						end
					end
				end
				default: take = e_size_c > req_c && (!found_q || e_size_c > fsize_c);
			endcase
		end
	end

	assign split_c  = (fsize_c >= aligned_q + HB_C) && (count_x < MAXB_C);
	assign has_next = (fidx_x + XW'(1)) < count_x;
	assign has_prev = (fidx_q != '0);
	assign nf = has_next && !nx_used_q;
	assign pf = has_prev && !pv_used_q;

	assign kmerged_c = fsize_c + (nf ? CW'(nx_size_q) + HB_C : '0);
	assign pmerged_c = CW'(pv_size_q) + kmerged_c + HB_C;
	assign drop_n    = {1'b0, nf} + {1'b0, pf};
	assign m_src_x   = (pf && !nf) ? fidx_x + XW'(1) : fidx_x + XW'(2);
	assign m_run     = (drop_n != 2'd0) && (m_src_x < count_x);

	// The cursor follows entries that move and lands on a merged block.
	always_comb begin
		c1 = XW'(cursor_q);
		if (nf) begin
			if (c1 > fidx_x + XW'(1)) c1 = c1 - XW'(1);
			else if (c1 == fidx_x + XW'(1)) c1 = fidx_x;
		end
		c2 = c1;
		if (pf) begin
			if (c1 > fidx_x) c2 = c1 - XW'(1);
			else if (c1 == fidx_x) c2 = fidx_x - XW'(1);
		end
	end

	always_comb begin
		h1 = (CW'(heap_q) > TOP_C) ? TOP_C : CW'(heap_q);
		h2 = CW'((h1 / HEADER_BYTES) * HEADER_BYTES);
		h3 = (h2 < (HB_C << 1)) ? (HB_C << 1) : h2;
	end
	assign size0 = AW'(h3 - HB_C);

	assign pay_full_c = CW'(fstart_q) + HB_C;
	assign nstart_c   = CW'(fstart_q) + HB_C + aligned_q;
	assign nsize_c    = fsize_c - aligned_q - HB_C;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		if (cmd.init) begin
			we = 1'b1;
			wd = {1'b0, AW'(0), size0};
		end else if (cmd.alloc_split) begin
			we = 1'b1;
			wa = IW'(fidx_x + XW'(1));
			wd = {1'b0, nstart_c[AW-1:0], nsize_c[AW-1:0]};
		end else if (cmd.alloc_write) begin
			we = 1'b1;
			wa = fidx_q;
			wd = {1'b1, fstart_q, split_q ? aligned_q[AW-1:0] : fsize_q};
		end else if (cmd.merge) begin
			we = 1'b1;
			if (pf) begin
				wa = fidx_q - IW'(1);
				wd = {1'b0, pv_start_q, pmerged_c[AW-1:0]};
			end else begin
				wa = fidx_q;
				wd = {1'b0, fstart_q, kmerged_c[AW-1:0]};
			end
		end else if (sw_v_s1) begin
			we = 1'b1;
			wa = sw_dst_s1;
			wd = rd_q;
		end
	end

	always_comb begin
		if (cmd.rd_next) ra = IW'(fidx_x + XW'(1));
		else if (cmd.rd_prev) ra = fidx_q - IW'(1);
		else if (cmd.sweep) ra = sw_ptr_q;
		else ra = scan_addr;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= FIT_FIRST;
			heap_q    <= 17'd65536;
			func_q    <= FUNC_ALLOC;
			count_q   <= CNW'(1);
			cursor_q  <= '0;
			cur_v_q   <= 1'b0;
			scn_j_q   <= '0;
			scn_v_s1  <= 1'b0;
			found_q   <= 1'b0;
			exact_q   <= 1'b0;
			split_q   <= 1'b0;
			sw_run_q  <= 1'b0;
			sw_up_q   <= 1'b0;
			sw_dist_q <= 2'd0;
			sw_ptr_q  <= '0;
			sw_last_q <= '0;
			sw_v_s1   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.init) begin
				count_q <= CNW'(1);
				cur_v_q <= 1'b0;
			end
			if (cmd.load) begin
				func_q   <= s_tuser;
				scn_j_q  <= '0;
				scn_v_s1 <= 1'b0;
				found_q  <= 1'b0;
				exact_q  <= 1'b0;
			end
			if (cmd.scan) begin
				if (XW'(scn_j_q) < count_x) begin
					scn_j_q  <= scn_j_q + CNW'(1);
					scn_v_s1 <= 1'b1;
				end else begin
					scn_v_s1 <= 1'b0;
				end
				if (scn_v_s1 && take) begin
					found_q <= 1'b1;
					if (hit_exact) exact_q <= 1'b1;
				end
			end
			if (cmd.latch) split_q <= split_c;
			if (cmd.sw_up) begin
				sw_run_q  <= has_next;
				sw_up_q   <= 1'b1;
				sw_ptr_q  <= IW'(count_x - XW'(1));
				sw_last_q <= IW'(fidx_x + XW'(1));
			end
			if (cmd.alloc_split) count_q <= count_q + CNW'(1);
			if (cmd.alloc_write && policy_q == FIT_NEXT) begin
				cursor_q <= fidx_q;
				cur_v_q  <= 1'b1;
			end
			if (cmd.merge) begin
				count_q   <= CNW'(count_x - XW'(drop_n));
				if (cur_v_q) cursor_q <= IW'(c2);
				sw_run_q  <= m_run;
				sw_up_q   <= 1'b0;
				sw_dist_q <= drop_n;
				sw_ptr_q  <= IW'(m_src_x);
				sw_last_q <= IW'(count_x - XW'(1));
			end
			if (cmd.sweep) begin
				if (sw_run_q) begin
					sw_v_s1 <= 1'b1;
					if (sw_ptr_q == sw_last_q) sw_run_q <= 1'b0;
					else if (sw_up_q) sw_ptr_q <= sw_ptr_q - IW'(1);
					else sw_ptr_q <= sw_ptr_q + IW'(1);
				end else begin
					sw_v_s1 <= 1'b0;
				end
			end
			if (cmd.respond) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			// A register write restarts the heap and drops any work in flight.
			if (cfg_hit) begin
				if (cfg_index == REG_POLICY) policy_q <= cfg_data[1:0];
				else heap_q <= cfg_data;
				sw_run_q <= 1'b0;
				sw_v_s1  <= 1'b0;
				scn_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= s_tdata[15:0];
			off_q     <= s_tdata[31:16];
			aligned_q <= CW'(((CW'(s_tdata[15:0]) + HB_C - CW'(1)) / HEADER_BYTES) *
			                 HEADER_BYTES);
		end
		if (cmd.scan) begin
			scn_idx_s1 <= scan_addr;
			if (scn_v_s1 && take) begin
				fidx_q   <= scn_idx_s1;
				fstart_q <= e_start;
				fsize_q  <= e_size;
			end
		end
		if (cmd.cap_next) begin
			nx_used_q <= e_used;
			nx_size_q <= e_size;
		end
		if (cmd.cap_prev) begin
			pv_used_q  <= e_used;
			pv_start_q <= e_start;
			pv_size_q  <= e_size;
		end
		if (cmd.sweep && sw_run_q) begin
			sw_dst_s1 <= sw_up_q ? sw_ptr_q + IW'(1) : sw_ptr_q - IW'(sw_dist_q);
		end
		if (cmd.respond) begin
			status_q <= cmd.resp_status;
			pay_q    <= (cmd.resp_status == STS_DONE && func_q == FUNC_ALLOC) ?
			            pay_full_c[15:0] : 16'd0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = pay_q;
	assign m_tuser  = status_q;

	assign sts.cfg_hit    = cfg_hit;
	assign sts.scan_done  = (scn_j_q == count_q) && !scn_v_s1;
	assign sts.found      = found_q;
	assign sts.is_release = (func_q == FUNC_RELEASE);
	assign sts.split      = split_c;
	assign sts.sw_busy    = sw_run_q || sw_v_s1;
	assign sts.out_free   = !out_v_q || m_tready;

	`FPBA_ASSERT(a_count_range, (count_q != '0) && (XW'(count_q) <= MAXB_C), "block count out of range")
	`FPBA_ASSERT(a_resp_free, !cmd.respond || !out_v_q || m_tready, "result overwrites a pending result")
	`FPBA_ASSERT_NEXT(a_scan_count, cmd.scan, $stable(count_q), "block count moved during a scan")

endmodule

>>> sv/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: init, scan, split or merge, entry shift and result handoff.
// ----------------------------------------------------------------------------
module fpba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  fpba_pkg::sts_t sts,
	output fpba_pkg::cmd_t cmd
);
	import fpba_pkg::*;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_SWU    = 4'd4;
	localparam logic [3:0] S_ASPL   = 4'd5;
	localparam logic [3:0] S_AWR    = 4'd6;
	localparam logic [3:0] S_RN     = 4'd7;
	localparam logic [3:0] S_RP     = 4'd8;
	localparam logic [3:0] S_RC     = 4'd9;
	localparam logic [3:0] S_RM     = 4'd10;
	localparam logic [3:0] S_SWD    = 4'd11;
	localparam logic [3:0] S_RESP   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] rs_q;
	logic [1:0] rs_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		rs_d = rs_q;
		s_tready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.latch = 1'b1;
				if (!sts.found) begin
					rs_d = sts.is_release ? STS_IGNORED : STS_NOFIT;
					state_d = S_RESP;
				end else if (sts.is_release) begin
					state_d = S_RN;
				end else if (sts.split) begin
					cmd.sw_up = 1'b1;
					state_d = S_SWU;
				end else begin
					state_d = S_AWR;
				end
			end
			S_SWU: begin
				cmd.sweep = 1'b1;
				if (!sts.sw_busy) state_d = S_ASPL;
			end
			S_ASPL: begin
				cmd.alloc_split = 1'b1;
				state_d = S_AWR;
			end
			S_AWR: begin
				cmd.alloc_write = 1'b1;
				rs_d = STS_DONE;
				state_d = S_RESP;
			end
			S_RN: begin
				cmd.rd_next = 1'b1;
				state_d = S_RP;
			end
			S_RP: begin
				cmd.cap_next = 1'b1;
				cmd.rd_prev = 1'b1;
				state_d = S_RC;
			end
			S_RC: begin
				cmd.cap_prev = 1'b1;
				state_d = S_RM;
			end
			S_RM: begin
				cmd.merge = 1'b1;
				state_d = S_SWD;
			end
			S_SWD: begin
				cmd.sweep = 1'b1;
				if (!sts.sw_busy) begin
					rs_d = STS_DONE;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				cmd.resp_status = rs_q;
				if (sts.out_free) begin
					cmd.respond = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			rs_q <= STS_DONE;
		end else begin
			state_q <= sts.cfg_hit ? S_INIT : state_d;
			rs_q <= rs_d;
		end
	end

endmodule

>>> sv/fit_policy_block_allocator.sv
// An allocate scans all N table entries and, when block k, counted from zero, is
// split, first shifts the entries above it up; a release scans, reads both
// neighbours and shifts the later entries down after a merge. One request is in
// work at a time; the scan reads one table entry per cycle, as does a shift.
// After reset and after each register write the table is rebuilt.
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Heap block allocator with first, next, best and worst fit and coalescing.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int HEAP_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // request_bytes [15:0], release_offset [31:16]
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // payload_offset [15:0]
	output logic [1:0]  m_tuser   // status [1:0]
);
	import fpba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpba_dp #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.HEADER_BYTES   (HEADER_BYTES),
		.HEAP_ADDR_BITS (HEAP_ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
